// ===== design/c3z_pkg.sv =====
// shared constants, types and register codes of the 3x3 zero padded convolution stream
package c3z_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int MAX_ROWS    = 1024;

    localparam int COL_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int ROW_W     = $clog2(MAX_ROWS + 1);
    localparam int SIZE_W    = 11;
    localparam int COEF_W    = 48;
    localparam int WEIGHT_W  = 16;
    localparam int PIX_W     = 8;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int PROD_W    = PIX_W + 1 + WEIGHT_W;
    localparam int SUM_W     = 28;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH     = 3'd0,
        CFG_IMAGE_HEIGHT    = 3'd1,
        CFG_COEF_TOP_ROW    = 3'd2,
        CFG_COEF_MID_ROW    = 3'd3,
        CFG_COEF_BOTTOM_ROW = 3'd4
    } c3z_cfg_idx_t;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel;
    } c3z_in_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] weighted_sum;
        logic                    last;
    } c3z_out_t;

    // one window column: index 0 top, 1 middle, 2 bottom
    typedef logic [2:0][PIX_W-1:0] c3z_col_t;

    typedef struct packed {
        logic shifted;
        logic last;
    } c3z_issue_t;

endpackage

// ===== design/c3z_ram.sv =====
// generic single write port ram with registered read
module c3z_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/c3z_cell.sv =====
// one window column cell, loads its right neighbor (or the new column) on each shift, zeros on clear
module c3z_cell import c3z_pkg::*; (
    input  logic     clk,
    input  logic     shift_en,
    input  logic     clear,
    input  c3z_col_t din,
    output c3z_col_t dout
);

    c3z_col_t col_reg;
    c3z_col_t col_next;

    always_comb begin
        col_next = col_reg;
        if (shift_en) begin
            col_next = clear ? '0 : din;
        end
    end

    always_ff @(posedge clk) begin
        col_reg <= col_next;
    end

    assign dout = col_reg;

endmodule

// ===== design/c3z_mac.sv =====
// weighted sum of the window: product stage, then sum stage into the output register
module c3z_mac import c3z_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  c3z_issue_t             ctl,
    input  c3z_col_t [2:0]         win,
    input  logic [2:0][COEF_W-1:0] coef,
    output logic                   m_valid,
    input  logic                   m_ready,
    output c3z_out_t               m_data
);

    logic                     p_valid_reg, p_valid_next;
    logic                     p_last_reg;
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic                     m_valid_reg, m_valid_next;
    c3z_out_t                 m_data_reg;
    logic signed [SUM_W-1:0]  sum;
    logic                     p_en;
    logic                     s_en;

    assign s_en     = !m_valid_reg || m_ready;
    assign p_en     = !p_valid_reg || s_en;
    assign in_ready = p_en;

    // shifted: left neighbor is window column 1, right neighbor is padding
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                logic [PIX_W-1:0]    px;
                logic [WEIGHT_W-1:0] wt;
                px = '0;
                wt = coef[r][WEIGHT_W*k +: WEIGHT_W];
                if (!ctl.shifted) begin
                    px = win[k][r];
                end else if (k < 2) begin
                    px = win[k+1][r];
                end
                prod_next[r][k] = PROD_W'($signed({1'b0, px})) * PROD_W'($signed(wt));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                sum = sum + SUM_W'(prod_reg[r][k]);
            end
        end
    end

    always_comb begin
        p_valid_next = p_valid_reg;
        if (p_en) begin
            p_valid_next = in_valid;
        end
        m_valid_next = m_valid_reg;
        if (s_en) begin
            m_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= p_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_en && in_valid) begin
            prod_reg   <= prod_next;
            p_last_reg <= ctl.shifted && ctl.last;
        end
        if (s_en && p_valid_reg) begin
            m_data_reg.weighted_sum <= sum;
            m_data_reg.last         <= p_last_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_last_only_from_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        s_en && p_valid_reg |=> m_data_reg.last == $past(p_last_reg))
        else $error("last flag on output differs from the product beat");

endmodule

// ===== design/conv3x3_zero_pad_stream.sv =====
// top level: 3x3 zero padded image convolution over a raster pixel stream
// path: fetch registers, window cells, product and output registers, from the completing beat
// (one row and one column past centre, one row at a row end; drain beats flush the last row)
// throughput: one pixel per cycle while output is taken; input stalls at a row's last column
// where two results leave the single shared multiply-add unit
// reset: counters, valids cleared, config to defaults; left two window cols clear at row start
module conv3x3_zero_pad_stream import c3z_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  c3z_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output c3z_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

    // configuration
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [COEF_W-1:0] coef_top_reg, coef_mid_reg, coef_bot_reg;
    logic [SIZE_W-1:0] w_eff, h_eff;

    // counters
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // fetch stage
    logic             a_valid_reg, a_valid_next;
    logic [COL_W-1:0] a_col_reg;
    logic [PIX_W-1:0] a_v_reg;
    logic             a_row1_reg, a_row2_reg, a_first_reg;
    logic             a_emit0_reg, a_emit1_reg, a_last_reg;
    logic             a_fwd_reg;
    logic [PIX_W-1:0] a_fwd_top_reg, a_fwd_mid_reg;
    logic [LINE_W-1:0] line_rd;
    logic [PIX_W-1:0] a_top_raw, a_mid_raw;

    // window stage
    logic           b_pend0_reg, b_pend0_next;
    logic           b_pend1_reg, b_pend1_next;
    logic           b_last_reg;
    c3z_col_t [2:0] win;
    c3z_col_t       new_col;

    logic       s_fire, a_fire, a_en, b_free;
    logic       last_col, drain;
    logic [PIX_W-1:0] v_in;
    logic       issue_valid, issue_fire, mac_ready;
    c3z_issue_t issue;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= SIZE_W'(MAX_COLUMNS);
            height_reg   <= SIZE_W'(MAX_ROWS);
            coef_top_reg <= '0;
            coef_mid_reg <= COEF_W'(4096);
            coef_bot_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:     width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_IMAGE_HEIGHT:    height_reg   <= cfg_data[SIZE_W-1:0];
                CFG_COEF_TOP_ROW:    coef_top_reg <= cfg_data;
                CFG_COEF_MID_ROW:    coef_mid_reg <= cfg_data;
                CFG_COEF_BOTTOM_ROW: coef_bot_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = SIZE_W'(1);
        end else if (width_reg > SIZE_W'(MAX_COLUMNS)) begin
            w_eff = SIZE_W'(MAX_COLUMNS);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg == '0) begin
            h_eff = SIZE_W'(1);
        end else if (height_reg > SIZE_W'(MAX_ROWS)) begin
            h_eff = SIZE_W'(MAX_ROWS);
        end else begin
            h_eff = height_reg;
        end
    end

    // handshake chain
    assign a_en    = !a_valid_reg || a_fire;
    assign s_ready = a_en;
    assign s_fire  = s_valid && s_ready;
    assign a_fire  = a_valid_reg && b_free;

    assign last_col = col_reg >= COL_W'(w_eff - SIZE_W'(1));
    assign drain    = row_reg >= ROW_W'(h_eff);
    assign v_in     = (s_data.kind || drain) ? '0 : s_data.pixel;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_fire) begin
            if (last_col) begin
                col_next = '0;
                row_next = drain ? '0 : ROW_W'(row_reg + 1'b1);
            end else begin
                col_next = COL_W'(col_reg + 1'b1);
            end
        end
        a_valid_next = a_valid_reg;
        if (a_en) begin
            a_valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_pend0_reg <= 1'b0;
            b_pend1_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
            b_pend0_reg <= b_pend0_next;
            b_pend1_reg <= b_pend1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_col_reg     <= col_reg;
            a_v_reg       <= v_in;
            a_row1_reg    <= row_reg != '0;
            a_row2_reg    <= row_reg >= ROW_W'(2);
            a_first_reg   <= col_reg == '0;
            a_emit0_reg   <= (row_reg != '0) && (col_reg != '0);
            a_emit1_reg   <= (row_reg != '0) && last_col;
            a_last_reg    <= row_reg == ROW_W'(h_eff);
            a_fwd_reg     <= a_fire && (a_col_reg == col_reg);
            a_fwd_top_reg <= a_mid_raw;
            a_fwd_mid_reg <= a_v_reg;
        end
        if (a_fire) begin
            b_last_reg <= a_last_reg;
        end
    end

    // line store pair: upper byte two rows above, lower byte one row above
    c3z_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_COLUMNS)
    ) u_line (
        .clk     (aclk),
        .wr_en   (a_fire),
        .wr_addr (a_col_reg),
        .wr_data ({a_mid_raw, a_v_reg}),
        .rd_en   (s_fire),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    assign a_top_raw = a_fwd_reg ? a_fwd_top_reg : line_rd[LINE_W-1:PIX_W];
    assign a_mid_raw = a_fwd_reg ? a_fwd_mid_reg : line_rd[PIX_W-1:0];

    // padding above the image comes from the row count
    assign new_col[0] = a_row2_reg ? a_top_raw : '0;
    assign new_col[1] = a_row1_reg ? a_mid_raw : '0;
    assign new_col[2] = a_v_reg;

    for (genvar g = 0; g < 3; g++) begin : g_cell
        c3z_cell u_cell (
            .clk      (aclk),
            .shift_en (a_fire),
            .clear    (a_first_reg && (g < 2)),
            .din      ((g == 2) ? new_col : win[(g == 2) ? 2 : g + 1]),
            .dout     (win[g])
        );
    end

    // results of one beat go out one per cycle when accepted, centred first, then the row end
    assign issue_valid   = b_pend0_reg || b_pend1_reg;
    assign issue.shifted = !b_pend0_reg;
    assign issue.last    = b_last_reg;
    assign issue_fire    = issue_valid && mac_ready;
    assign b_free        = !issue_valid || (issue_fire && !(b_pend0_reg && b_pend1_reg));

    always_comb begin
        b_pend0_next = b_pend0_reg;
        b_pend1_next = b_pend1_reg;
        if (a_fire) begin
            b_pend0_next = a_emit0_reg;
            b_pend1_next = a_emit1_reg;
        end else if (issue_fire) begin
            if (b_pend0_reg) begin
                b_pend0_next = 1'b0;
            end else begin
                b_pend1_next = 1'b0;
            end
        end
    end

    c3z_mac u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (issue_valid),
        .in_ready (mac_ready),
        .ctl      (issue),
        .win      (win),
        .coef     ({coef_bot_reg, coef_mid_reg, coef_top_reg}),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    a_drain_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && last_col && drain |=> (row_reg == '0) && (col_reg == '0))
        else $error("counters did not wrap after the drain row");

    a_window_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        a_fire |-> !(b_pend0_reg && b_pend1_reg))
        else $error("window shifted with two results still pending");

    a_shifted_order: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_fire && b_pend0_reg && b_pend1_reg |=> b_pend1_reg && !b_pend0_reg)
        else $error("row end result lost after centred result");

endmodule

// ===== dv/c3z_stream_checker.sv =====
// scoreboard for the 3x3 zero padded convolution stream: tracks config, predicts sums, compares
module c3z_stream_checker import c3z_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  c3z_in_t              s_data,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  c3z_out_t             m_data,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data,
    output int                   mismatch_count,
    output int                   sums_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    // 0 top row, 1 middle row, 2 bottom row
    logic [COEF_W-1:0] coef_reg [3];

    logic [PIX_W-1:0] row_prev [MAX_COLUMNS];
    logic [PIX_W-1:0] row_prev2 [MAX_COLUMNS];
    // [row top..bottom][column left..right]
    logic [PIX_W-1:0] win [3][3];
    int col_pos;
    int row_pos;

    c3z_out_t sum_q [$];

    function automatic int eff_size(int v, int lim);
        return (v == 0) ? 1 : ((v > lim) ? lim : v);
    endfunction

    // shifted: left neighbour is window column 1, right neighbour is padding
    function automatic logic signed [SUM_W-1:0] window_sum(bit shifted);
        longint acc;
        int src;
        logic signed [WEIGHT_W-1:0] wt;
        acc = 0;
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                src = shifted ? k + 1 : k;
                wt = coef_reg[r][WEIGHT_W*k +: WEIGHT_W];
                if (src < 3) begin
                    acc += longint'(win[r][src]) * longint'(wt);
                end
            end
        end
        return acc[SUM_W-1:0];
    endfunction

    function automatic void step_pixel(c3z_in_t beat);
        int w;
        int h;
        int c;
        int r;
        bit last_col;
        bit drain_row;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] above2;
        logic [PIX_W-1:0] above1;
        c3z_out_t res;
        w = eff_size(int'(width_reg), MAX_COLUMNS);
        h = eff_size(int'(height_reg), MAX_ROWS);
        c = col_pos;
        r = row_pos;
        last_col = (c >= w - 1);
        drain_row = (r >= h);
        v = (beat.kind || drain_row) ? '0 : beat.pixel;
        above2 = (r >= 2) ? row_prev2[c] : '0;
        above1 = (r >= 1) ? row_prev[c] : '0;
        for (int k = 0; k < 3; k++) begin
            if (c == 0) begin
                win[k][0] = '0;
                win[k][1] = '0;
            end else begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
        end
        win[0][2] = above2;
        win[1][2] = above1;
        win[2][2] = v;
        if (r >= 1) begin
            if (c >= 1) begin
                res.weighted_sum = window_sum(1'b0);
                res.last = 1'b0;
                sum_q.push_back(res);
            end
            if (last_col) begin
                res.weighted_sum = window_sum(1'b1);
                res.last = (r == h);
                sum_q.push_back(res);
            end
        end
        row_prev2[c] = row_prev[c];
        row_prev[c] = v;
        if (last_col) begin
            col_pos = 0;
            row_pos = drain_row ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("%0t ns sum check: %s", $time, msg);
        mismatch_count++;
    endtask

    always @(posedge aclk) begin : watch
        c3z_out_t want;
        if (!aresetn) begin
            width_reg = SIZE_W'(MAX_COLUMNS);
            height_reg = SIZE_W'(MAX_ROWS);
            coef_reg[0] = '0;
            coef_reg[1] = 48'h1000;
            coef_reg[2] = '0;
            win = '{default: '0};
            col_pos = 0;
            row_pos = 0;
            sum_q.delete();
            mismatch_count = 0;
            sums_waiting = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IMAGE_WIDTH:     width_reg = cfg_data[SIZE_W-1:0];
                    CFG_IMAGE_HEIGHT:    height_reg = cfg_data[SIZE_W-1:0];
                    CFG_COEF_TOP_ROW:    coef_reg[0] = cfg_data;
                    CFG_COEF_MID_ROW:    coef_reg[1] = cfg_data;
                    CFG_COEF_BOTTOM_ROW: coef_reg[2] = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (sum_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat, weighted_sum %0d last %0b",
                                              m_data.weighted_sum, m_data.last));
                end else begin
                    want = sum_q.pop_front();
                    if (m_data.weighted_sum !== want.weighted_sum) begin
                        report_mismatch($sformatf("weighted_sum %0d, expected %0d",
                                                  m_data.weighted_sum, want.weighted_sum));
                    end
                    if (m_data.last !== want.last) begin
                        report_mismatch($sformatf("last %0b, expected %0b (weighted_sum %0d)",
                                                  m_data.last, want.last, want.weighted_sum));
                    end
                end
            end
            if (s_valid && s_ready) begin
                step_pixel(s_data);
            end
            sums_waiting = sum_q.size();
        end
    end

endmodule

// ===== dv/tb_conv3x3_zero_pad_stream.sv =====
// testbench top for the 3x3 zero padded convolution stream: clock, reset, stimulus, verdict
module tb_conv3x3_zero_pad_stream;
    timeunit 1ns;
    timeprecision 1ps;

    import c3z_pkg::*;

    localparam int SETTLE_CYCLES = 12;
    localparam int TOTAL_BEATS   = 1450;

    localparam logic [WEIGHT_W-1:0] W_MIN = 16'h8000;
    localparam logic [WEIGHT_W-1:0] W_MAX = 16'h7FFF;
    localparam logic [WEIGHT_W-1:0] W_ONE = 16'h1000;
    localparam logic [SIZE_W-1:0]   SIZE_ALL_ONES = '1;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    c3z_in_t              s_data;
    logic                 m_valid;
    logic                 m_ready;
    c3z_out_t             m_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    int mismatch_count;
    int sums_waiting;

    // frame position and sizes as the sender sees them
    int cur_w;
    int cur_h;
    int pos_col;
    int pos_row;
    bit frame_done;
    int beats_sent;
    bit tx_burst;
    bit rx_burst;

    conv3x3_zero_pad_stream i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    c3z_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .sums_waiting   (sums_waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("conv3x3_zero_pad_stream regression: fail");
        $finish;
    end

    initial begin : result_sink
        int stall;
        m_ready = 1'b0;
        forever begin
            stall = rx_burst ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic int fit_size(int v, int lim);
        return (v == 0) ? 1 : ((v > lim) ? lim : v);
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        logic [COEF_W-1:0] coef;
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 4))
                0: coef[WEIGHT_W*k +: WEIGHT_W] = W_MIN;
                1: coef[WEIGHT_W*k +: WEIGHT_W] = W_MAX;
                2: coef[WEIGHT_W*k +: WEIGHT_W] = '0;
                3: coef[WEIGHT_W*k +: WEIGHT_W] = W_ONE;
                default: coef[WEIGHT_W*k +: WEIGHT_W] = WEIGHT_W'($urandom);
            endcase
        end
        return coef;
    endfunction

    // leaves cfg_valid high; callers lower it after their last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_IMAGE_WIDTH) begin
            cur_w = fit_size(int'(data[SIZE_W-1:0]), MAX_COLUMNS);
        end
        if (idx == CFG_IMAGE_HEIGHT) begin
            cur_h = fit_size(int'(data[SIZE_W-1:0]), MAX_ROWS);
        end
    endtask

    task automatic set_frame(input int w, input int h, input logic [COEF_W-1:0] coef_t,
                             input logic [COEF_W-1:0] coef_m, input logic [COEF_W-1:0] coef_b);
        write_reg(CFG_IMAGE_WIDTH, COEF_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, COEF_W'(h));
        write_reg(CFG_COEF_TOP_ROW, coef_t);
        write_reg(CFG_COEF_MID_ROW, coef_m);
        write_reg(CFG_COEF_BOTTOM_ROW, coef_b);
        cfg_valid <= 1'b0;
    endtask

    // hold the input until every sum is out and the pipeline has emptied
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (sums_waiting == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_beat(input logic drain_tick, input logic [PIX_W-1:0] value);
        int gap;
        s_valid <= 1'b1;
        s_data  <= '{kind: drain_tick, pixel: value};
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        frame_done = 1'b0;
        if (pos_col >= cur_w - 1) begin
            pos_col = 0;
            frame_done = (pos_row >= cur_h);
            pos_row = frame_done ? 0 : pos_row + 1;
        end else begin
            pos_col++;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // one frame plus drain row; noise flips beat kinds, a pause may resize or set mid coefs
    task automatic run_frame(input int noise_pct, input bit allow_pause);
        int pause_at;
        int n;
        logic drain_tick;
        logic [PIX_W-1:0] value;
        pause_at = -1;
        if (allow_pause && $urandom_range(0, 4) == 0) begin
            pause_at = $urandom_range(0, (cur_h + 1) * cur_w - 1);
        end
        n = 0;
        frame_done = 1'b0;
        while (!frame_done) begin
            if (n == pause_at) begin
                settle();
                case ($urandom_range(0, 2))
                    0: write_reg(CFG_IMAGE_HEIGHT, COEF_W'($urandom_range(0, cur_h + 2)));
                    1: write_reg(CFG_IMAGE_WIDTH, COEF_W'($urandom_range(1, cur_w)));
                    default: write_reg(CFG_COEF_MID_ROW, rand_coef());
                endcase
                cfg_valid <= 1'b0;
            end
            drain_tick = (pos_row >= cur_h);
            if ($urandom_range(0, 99) < noise_pct) begin
                drain_tick = !drain_tick;
            end
            case ($urandom_range(0, 7))
                0: value = '0;
                1: value = '1;
                default: value = PIX_W'($urandom);
            endcase
            send_beat(drain_tick, value);
            n++;
        end
    endtask

    initial begin
        int w;
        int h;
        logic drain_tick;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_IMAGE_WIDTH;
        cfg_data   = '0;
        cur_w      = MAX_COLUMNS;
        cur_h      = MAX_ROWS;
        pos_col    = 0;
        pos_row    = 0;
        beats_sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // start a row at reset sizes, then shrink the width past the current column
        for (int i = 0; i < 6; i++) begin
            send_beat(1'b0, (i == 3) ? 8'h00 : 8'hFF);
        end
        settle();
        write_reg(CFG_IMAGE_WIDTH, COEF_W'(4));
        write_reg(CFG_IMAGE_HEIGHT, COEF_W'(3));
        write_reg(CFG_COEF_TOP_ROW, {3{W_MIN}});
        write_reg(CFG_COEF_MID_ROW, {3{W_MIN}});
        write_reg(CFG_COEF_BOTTOM_ROW, {3{W_MIN}});
        cfg_valid <= 1'b0;
        // drain tick inside a frame row, pixel inside the drain row
        while (!frame_done) begin
            drain_tick = (pos_row >= cur_h);
            if (pos_row == 2 && pos_col == cur_w - 1) begin
                drain_tick = 1'b1;
            end
            if (pos_row == cur_h && pos_col == 0) begin
                drain_tick = 1'b0;
            end
            send_beat(drain_tick, 8'hFF);
        end

        // zero sizes act as one; indexes past the register list are ignored
        settle();
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, '0);
        write_reg(CFG_COEF_TOP_ROW, {3{W_MAX}});
        write_reg(CFG_COEF_MID_ROW, {3{W_MAX}});
        write_reg(CFG_COEF_BOTTOM_ROW, {3{W_MAX}});
        for (int i = CFG_COEF_BOTTOM_ROW + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_reg(CFG_IDX_W'(i), '1);
        end
        cfg_valid <= 1'b0;
        send_beat(1'b0, 8'hFF);
        send_beat(1'b1, 8'hA5);

        // oversized width clamps to the maximum: one full row, then a narrow drain row
        settle();
        set_frame(int'(SIZE_ALL_ONES), 1, rand_coef(), rand_coef(), rand_coef());
        for (int i = 0; i < MAX_COLUMNS; i++) begin
            send_beat(1'b0, PIX_W'($urandom));
        end
        settle();
        write_reg(CFG_IMAGE_WIDTH, COEF_W'(4));
        cfg_valid <= 1'b0;
        run_frame(0, 1'b0);

        while (beats_sent < TOTAL_BEATS) begin
            settle();
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 19))
                0: w = 0;
                1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: w = $urandom_range(1, 8);
                19: w = $urandom_range(41, 130);
                default: w = $urandom_range(9, 40);
            endcase
            h = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 6);
            set_frame(w, h, rand_coef(), rand_coef(), rand_coef());
            run_frame(8, 1'b1);
        end

        settle();
        if (mismatch_count == 0 && sums_waiting == 0) begin
            $display("conv3x3_zero_pad_stream regression: pass");
        end else begin
            $display("conv3x3_zero_pad_stream regression: fail");
        end
        $finish;
    end

endmodule
